@@ hw/rtl/ddays_pkg.sv @@
// Shared widths, constants and calendar tables for the date difference block.
package ddays_pkg;

	localparam int unsigned MONTH_W = 4;
	localparam int unsigned DAY_W   = 5;
	localparam int unsigned YEAR_W  = 14;
	localparam int unsigned DIFF_W  = 23;

	// Years above this limit are pulled down to it before any use.
	localparam int unsigned MAX_YEAR = 9999;

	// Reciprocal for dividing values of up to 12 bits by 25: q = (x * 5243) >> 17.
	localparam int unsigned DIV25_MUL   = 5243;
	localparam int unsigned DIV25_SHIFT = 17;
	localparam int unsigned PROD_W      = 25;
	localparam int unsigned QUOT_W      = PROD_W - DIV25_SHIFT;

	localparam logic [3:0] MONTH_JAN = 4'd1;
	localparam logic [3:0] MONTH_FEB = 4'd2;
	localparam logic [3:0] MONTH_MAR = 4'd3;
	localparam logic [3:0] MONTH_APR = 4'd4;
	localparam logic [3:0] MONTH_MAY = 4'd5;
	localparam logic [3:0] MONTH_JUN = 4'd6;
	localparam logic [3:0] MONTH_JUL = 4'd7;
	localparam logic [3:0] MONTH_AUG = 4'd8;
	localparam logic [3:0] MONTH_SEP = 4'd9;
	localparam logic [3:0] MONTH_OCT = 4'd10;
	localparam logic [3:0] MONTH_NOV = 4'd11;
	localparam logic [3:0] MONTH_DEC = 4'd12;

	// Length of a month; zero for codes that are not a month, so no day fits.
	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] len;
		unique case (m)
			MONTH_JAN, MONTH_MAR, MONTH_MAY, MONTH_JUL,
			MONTH_AUG, MONTH_OCT, MONTH_DEC: len = 5'd31;
			MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
			MONTH_FEB: len = leap ? 5'd29 : 5'd28;
			default: len = 5'd0;
		endcase
		return len;
	endfunction

	// Days in the year before the first of the month.
	function automatic logic [8:0] days_before(input logic [3:0] m, input logic leap);
		logic [8:0] base;
		logic       late;
		late = 1'b1;
		unique case (m)
			MONTH_JAN: begin
				base = 9'd0;
				late = 1'b0;
			end
			MONTH_FEB: begin
				base = 9'd31;
				late = 1'b0;
			end
			MONTH_MAR: base = 9'd59;
			MONTH_APR: base = 9'd90;
			MONTH_MAY: base = 9'd120;
			MONTH_JUN: base = 9'd151;
			MONTH_JUL: base = 9'd181;
			MONTH_AUG: base = 9'd212;
			MONTH_SEP: base = 9'd243;
			MONTH_OCT: base = 9'd273;
			MONTH_NOV: base = 9'd304;
			MONTH_DEC: base = 9'd334;
			default: begin
				base = 9'd0;
				late = 1'b0;
			end
		endcase
		return base + {8'd0, late & leap};
	endfunction

	// Multiply a quotient by 25 with shifts and adds.
	function automatic logic [11:0] times25(input logic [QUOT_W-1:0] q);
		logic [11:0] w;
		w = {4'd0, q};
		return (w << 4) + (w << 3) + w;
	endfunction

endpackage

@@ hw/rtl/ddays_in_if.sv @@
// Input channel: one word holds the two dates to compare.
interface ddays_in_if;
	logic                           valid;
	logic                           ready;
	logic [ddays_pkg::MONTH_W-1:0]  first_month;
	logic [ddays_pkg::DAY_W-1:0]    first_day;
	logic [ddays_pkg::YEAR_W-1:0]   first_year;
	logic [ddays_pkg::MONTH_W-1:0]  second_month;
	logic [ddays_pkg::DAY_W-1:0]    second_day;
	logic [ddays_pkg::YEAR_W-1:0]   second_year;

	modport source (
		output valid, first_month, first_day, first_year,
		output second_month, second_day, second_year,
		input  ready
	);
	modport sink (
		input  valid, first_month, first_day, first_year,
		input  second_month, second_day, second_year,
		output ready
	);
endinterface

@@ hw/rtl/ddays_out_if.sv @@
// Output channel: one word holds the day difference and both validity flags.
interface ddays_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [ddays_pkg::DIFF_W-1:0] day_difference;
	logic                                first_valid;
	logic                                second_valid;

	modport source (
		output valid, day_difference, first_valid, second_valid,
		input  ready
	);
	modport sink (
		input  valid, day_difference, first_valid, second_valid,
		output ready
	);
endinterface

@@ hw/rtl/date_difference_in_days.sv @@
// A word accepted on the input channel passes through the four stages in order and shows
// on the result channel from the last. One date pair per cycle while the result side is
// ready; each stage holds one word and moves on as soon as the stage after it is free, so
// bubbles close up under a stall. The four stages are: year clamp and constant multiplies,
// leap test and lookups, serial day sum, and the subtraction held in the output register.
// Reset (arst_n low, asynchronous) empties every stage; payload registers are not reset.
module date_difference_in_days (
	input logic            clk,
	input logic            arst_n,
	ddays_in_if.sink       dates,
	ddays_out_if.source    result
);

	localparam int unsigned YW = ddays_pkg::YEAR_W;
	localparam int unsigned PW = ddays_pkg::PROD_W;
	localparam int unsigned QW = ddays_pkg::QUOT_W;
	localparam int unsigned DW = ddays_pkg::DIFF_W;

	// Each date travels in a lane of its own; lane 0 is the first date.
	logic [ddays_pkg::MONTH_W-1:0] month_in [2];
	logic [ddays_pkg::DAY_W-1:0]   day_in   [2];
	logic [YW-1:0]                 year_in  [2];

	// Stage valid bits and the stall chain. A stage takes a new word when it is
	// empty or when its current word moves on in the same cycle.
	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic en_s1, en_s2, en_s3, en_s4;

	assign en_s4 = !valid_s4 || result.ready;
	assign en_s3 = !valid_s3 || en_s4;
	assign en_s2 = !valid_s2 || en_s3;
	assign en_s1 = !valid_s1 || en_s2;
	assign dates.ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en_s1) valid_s1 <= dates.valid;
			if (en_s2) valid_s2 <= valid_s1;
			if (en_s3) valid_s3 <= valid_s2;
			if (en_s4) valid_s4 <= valid_s3;
		end
	end

	assign month_in[0] = dates.first_month;
	assign day_in[0]   = dates.first_day;
	assign year_in[0]  = dates.first_year;
	assign month_in[1] = dates.second_month;
	assign day_in[1]   = dates.second_day;
	assign year_in[1]  = dates.second_year;

	// Stage 1: the year is clamped and n = year - 1 formed (zero for years 0 and 1).
	// All divisions by 100 and 400 are taken as a shift by 2 or 4 followed by a
	// division by 25, done here as a multiply by a reciprocal. The leap test needs
	// the same quotients of the year itself. n * 365 is a constant multiply.
	logic [YW-1:0] year_c [2];
	logic [YW-1:0] n_c    [2];
	logic [PW-1:0] py4_c  [2];
	logic [PW-1:0] py16_c [2];
	logic [PW-1:0] pn4_c  [2];
	logic [PW-1:0] pn16_c [2];
	logic [DW-1:0] n365_c [2];

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			if ({3'd0, year_in[i]} > 17'(ddays_pkg::MAX_YEAR)) begin
				year_c[i] = YW'(ddays_pkg::MAX_YEAR);
			end else begin
				year_c[i] = year_in[i];
			end
			n_c[i]    = (year_c[i] > YW'(1)) ? year_c[i] - YW'(1) : '0;
			py4_c[i]  = {13'd0, year_c[i][YW-1:2]} * PW'(ddays_pkg::DIV25_MUL);
			py16_c[i] = {15'd0, year_c[i][YW-1:4]} * PW'(ddays_pkg::DIV25_MUL);
			pn4_c[i]  = {13'd0, n_c[i][YW-1:2]} * PW'(ddays_pkg::DIV25_MUL);
			pn16_c[i] = {15'd0, n_c[i][YW-1:4]} * PW'(ddays_pkg::DIV25_MUL);
			n365_c[i] = DW'(n_c[i]) * DW'(365);
		end
	end

	logic [ddays_pkg::MONTH_W-1:0] month_s1 [2];
	logic [ddays_pkg::DAY_W-1:0]   day_s1   [2];
	logic [YW-1:0]                 year_s1  [2];
	logic [YW-1:0]                 n_s1     [2];
	logic [PW-1:0]                 py4_s1   [2];
	logic [PW-1:0]                 py16_s1  [2];
	logic [PW-1:0]                 pn4_s1   [2];
	logic [PW-1:0]                 pn16_s1  [2];
	logic [DW-1:0]                 n365_s1  [2];

	always_ff @(posedge clk) begin
		if (en_s1) begin
			for (int i = 0; i < 2; i++) begin
				month_s1[i] <= month_in[i];
				day_s1[i]   <= day_in[i];
				year_s1[i]  <= year_c[i];
				n_s1[i]     <= n_c[i];
				py4_s1[i]   <= py4_c[i];
				py16_s1[i]  <= py16_c[i];
				pn4_s1[i]   <= pn4_c[i];
				pn16_s1[i]  <= pn16_c[i];
				n365_s1[i]  <= n365_c[i];
			end
		end
	end

	// Stage 2: a year is divisible by 100 when it is divisible by 4 and year/4 is a
	// multiple of 25, and by 400 when it is divisible by 16 and year/16 is a multiple
	// of 25. The leap flag then picks the month length and the days before the month.
	// The days of all whole years before this one are n*365 + n/4 - n/100 + n/400.
	logic [QW-1:0] qy4_c   [2];
	logic [QW-1:0] qy16_c  [2];
	logic          div100  [2];
	logic          div400  [2];
	logic          leap_c  [2];
	logic [4:0]    len_c   [2];
	logic          ok_c    [2];
	logic [8:0]    yd_c    [2];
	logic [DW-1:0] prior_c [2];

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			qy4_c[i]  = py4_s1[i][PW-1:ddays_pkg::DIV25_SHIFT];
			qy16_c[i] = py16_s1[i][PW-1:ddays_pkg::DIV25_SHIFT];
			div100[i] = (year_s1[i][1:0] == 2'd0)
				&& (ddays_pkg::times25(qy4_c[i]) == year_s1[i][YW-1:2]);
			div400[i] = (year_s1[i][3:0] == 4'd0)
				&& (ddays_pkg::times25(qy16_c[i]) == {2'd0, year_s1[i][YW-1:4]});
			leap_c[i] = div400[i] || ((year_s1[i][1:0] == 2'd0) && !div100[i]);
			len_c[i]  = ddays_pkg::month_len(month_s1[i], leap_c[i]);
			ok_c[i]   = (day_s1[i] != '0) && (day_s1[i] <= len_c[i]);
			yd_c[i]   = ddays_pkg::days_before(month_s1[i], leap_c[i]) + 9'(day_s1[i]);
			prior_c[i] = n365_s1[i] + DW'(n_s1[i][YW-1:2])
				- DW'(pn4_s1[i][PW-1:ddays_pkg::DIV25_SHIFT])
				+ DW'(pn16_s1[i][PW-1:ddays_pkg::DIV25_SHIFT]);
		end
	end

	logic [8:0]    yd_s2    [2];
	logic [DW-1:0] prior_s2 [2];
	logic          ok_s2    [2];

	always_ff @(posedge clk) begin
		if (en_s2) begin
			for (int i = 0; i < 2; i++) begin
				yd_s2[i]    <= yd_c[i];
				prior_s2[i] <= prior_c[i];
				ok_s2[i]    <= ok_c[i];
			end
		end
	end

	// Stage 3: the serial day of each date.
	logic [DW-1:0] serial_s3 [2];
	logic          ok_s3     [2];

	always_ff @(posedge clk) begin
		if (en_s3) begin
			for (int i = 0; i < 2; i++) begin
				serial_s3[i] <= prior_s2[i] + DW'(yd_s2[i]);
				ok_s3[i]     <= ok_s2[i];
			end
		end
	end

	// Stage 4: the difference wraps to the field width; it is forced to zero when
	// either date is invalid, while both flags are still reported.
	logic [DW-1:0] diff_s4;
	logic          ok1_s4;
	logic          ok2_s4;

	always_ff @(posedge clk) begin
		if (en_s4) begin
			diff_s4 <= (ok_s3[0] && ok_s3[1]) ? serial_s3[1] - serial_s3[0] : '0;
			ok1_s4  <= ok_s3[0];
			ok2_s4  <= ok_s3[1];
		end
	end

	assign result.valid          = valid_s4;
	assign result.day_difference = $signed(diff_s4);
	assign result.first_valid    = ok1_s4;
	assign result.second_valid   = ok2_s4;

endmodule

@@ bench/tb.sv @@
// Self-checking testbench for date_difference_in_days: directed table plus random date pairs.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	// One input word: the two dates as the block receives them.
	typedef struct packed {
		logic [ddays_pkg::MONTH_W-1:0] first_month;
		logic [ddays_pkg::DAY_W-1:0]   first_day;
		logic [ddays_pkg::YEAR_W-1:0]  first_year;
		logic [ddays_pkg::MONTH_W-1:0] second_month;
		logic [ddays_pkg::DAY_W-1:0]   second_day;
		logic [ddays_pkg::YEAR_W-1:0]  second_year;
	} date_pair_t;

	// One result word: the signed span in days and a flag per date.
	typedef struct packed {
		logic signed [ddays_pkg::DIFF_W-1:0] day_difference;
		logic                                first_valid;
		logic                                second_valid;
	} span_word_t;

	// A row of the directed table. When known is set, the expected word is typed
	// into the row; otherwise the calendar predictor below supplies it.
	typedef struct {
		date_pair_t pair;
		bit         known;
		span_word_t want;
	} date_row_t;

	localparam int unsigned RANDOM_PAIRS  = 550;
	localparam int unsigned IDLE_PERCENT  = 12;
	localparam int unsigned STEADY_FIRST  = 200;
	localparam int unsigned STEADY_LAST   = 330;
	localparam int unsigned DRAIN_CYCLES  = 12;
	localparam int unsigned CYCLE_LIMIT   = 200000;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	ddays_in_if  dates ();
	ddays_out_if result ();

	date_difference_in_days u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.dates  (dates),
		.result (result)
	);

	// 20 ns clock period.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	date_row_t   date_table[$];
	span_word_t  pending_spans[$];

	// While steady is set, neither side inserts idle cycles.
	bit          steady = 1'b0;
	int unsigned fail_count    = 0;
	int unsigned pairs_sent    = 0;
	int unsigned pairs_valid   = 0;
	int unsigned pairs_flagged = 0;
	int unsigned spans_checked = 0;
	int unsigned cycle_count   = 0;

	// ---------------------------------------------------------------------
	// Calendar predictor.
	// ---------------------------------------------------------------------

	// Years beyond the supported range are pulled down to the top year first;
	// the leap test for February validity uses the clamped year as well.
	function automatic int unsigned clamp_year(input logic [ddays_pkg::YEAR_W-1:0] y);
		return (y > ddays_pkg::MAX_YEAR) ? ddays_pkg::MAX_YEAR : int'(y);
	endfunction

	// Gregorian rule: every 400th year is a leap year, other centuries are not,
	// and the remaining multiples of four are. Year zero counts as a leap year.
	function automatic bit leap_year(input int unsigned y);
		return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
	endfunction

	// Month length; codes outside January to December have no days at all.
	function automatic int unsigned days_in_month(input logic [ddays_pkg::MONTH_W-1:0] m,
		input bit leap);
		case (m)
			ddays_pkg::MONTH_FEB: return leap ? 29 : 28;
			ddays_pkg::MONTH_APR, ddays_pkg::MONTH_JUN,
			ddays_pkg::MONTH_SEP, ddays_pkg::MONTH_NOV: return 30;
			ddays_pkg::MONTH_JAN, ddays_pkg::MONTH_MAR, ddays_pkg::MONTH_MAY,
			ddays_pkg::MONTH_JUL, ddays_pkg::MONTH_AUG, ddays_pkg::MONTH_OCT,
			ddays_pkg::MONTH_DEC: return 31;
			default: return 0;
		endcase
	endfunction

	function automatic bit date_ok(input logic [ddays_pkg::MONTH_W-1:0] m,
		input logic [ddays_pkg::DAY_W-1:0] d, input int unsigned y);
		return (d >= 1) && (d <= days_in_month(m, leap_year(y)));
	endfunction

	// Day count from the start of year 1: whole earlier years plus the days
	// of the current year. Years 0 and 1 contribute no whole years.
	function automatic int unsigned day_number(input logic [ddays_pkg::MONTH_W-1:0] m,
		input logic [ddays_pkg::DAY_W-1:0] d, input int unsigned y);
		int unsigned whole;
		int unsigned ahead;
		bit          leap;
		whole = 0;
		ahead = 0;
		leap  = leap_year(y);
		if (y > 1) begin
			whole = (y - 1) * 365 + (y - 1) / 4 - (y - 1) / 100 + (y - 1) / 400;
		end
		for (int k = ddays_pkg::MONTH_JAN; k < m; k++) begin
			ahead += days_in_month(ddays_pkg::MONTH_W'(k), leap);
		end
		return whole + ahead + d;
	endfunction

	function automatic span_word_t predict_span(input date_pair_t p);
		span_word_t  w;
		int unsigned y1;
		int unsigned y2;
		int          span;
		y1 = clamp_year(p.first_year);
		y2 = clamp_year(p.second_year);
		w.first_valid  = date_ok(p.first_month, p.first_day, y1);
		w.second_valid = date_ok(p.second_month, p.second_day, y2);
		span = 0;
		// An invalid date on either side forces the span to zero.
		if (w.first_valid && w.second_valid) begin
			span = int'(day_number(p.second_month, p.second_day, y2))
				- int'(day_number(p.first_month, p.first_day, y1));
		end
		w.day_difference = span[ddays_pkg::DIFF_W-1:0];
		return w;
	endfunction

	// ---------------------------------------------------------------------
	// Stimulus generation.
	// ---------------------------------------------------------------------

	function automatic void add_row(input logic [ddays_pkg::MONTH_W-1:0] m1, input int d1,
		input int y1, input logic [ddays_pkg::MONTH_W-1:0] m2, input int d2, input int y2,
		input bit known, input int span, input bit v1, input bit v2);
		date_row_t r;
		r.pair.first_month  = m1;
		r.pair.first_day    = ddays_pkg::DAY_W'(d1);
		r.pair.first_year   = ddays_pkg::YEAR_W'(y1);
		r.pair.second_month = m2;
		r.pair.second_day   = ddays_pkg::DAY_W'(d2);
		r.pair.second_year  = ddays_pkg::YEAR_W'(y2);
		r.known             = known;
		r.want.day_difference = ddays_pkg::DIFF_W'(span);
		r.want.first_valid    = v1;
		r.want.second_valid   = v2;
		date_table.push_back(r);
	endfunction

	// Years cluster at both ends of the range, and some are raw 14-bit values
	// so that the saturation above the top year gets exercised.
	function automatic logic [ddays_pkg::YEAR_W-1:0] pick_year();
		case ($urandom_range(9))
			0: return ddays_pkg::YEAR_W'($urandom_range(3));
			1: return ddays_pkg::YEAR_W'($urandom_range(ddays_pkg::MAX_YEAR - 3,
				ddays_pkg::MAX_YEAR));
			2: return ddays_pkg::YEAR_W'($urandom);
			default: return ddays_pkg::YEAR_W'($urandom_range(ddays_pkg::MAX_YEAR));
		endcase
	endfunction

	// Mostly real calendar dates; some sit just outside the month, and a few
	// are raw bit patterns for the month and the day.
	function automatic void pick_date(input logic [ddays_pkg::YEAR_W-1:0] y,
		output logic [ddays_pkg::MONTH_W-1:0] m, output logic [ddays_pkg::DAY_W-1:0] d);
		int unsigned sel;
		int unsigned len;
		sel = $urandom_range(99);
		m   = ddays_pkg::MONTH_W'($urandom_range(ddays_pkg::MONTH_JAN, ddays_pkg::MONTH_DEC));
		len = days_in_month(m, leap_year(clamp_year(y)));
		if (sel < 84) begin
			d = ddays_pkg::DAY_W'($urandom_range(1, len));
		end else if (sel < 92) begin
			d = sel[0] ? '0 : ddays_pkg::DAY_W'(len + 1);
		end else begin
			m = ddays_pkg::MONTH_W'($urandom);
			d = ddays_pkg::DAY_W'($urandom);
		end
	endfunction

	function automatic date_pair_t random_pair();
		date_pair_t p;
		p.first_year = pick_year();
		// A quarter of the pairs stay within a year of each other, which is
		// where the span is small and month and leap boundaries matter most.
		if ($urandom_range(3) == 0) begin
			p.second_year = ddays_pkg::YEAR_W'(p.first_year + $urandom_range(2) - 1);
		end else begin
			p.second_year = pick_year();
		end
		pick_date(p.first_year, p.first_month, p.first_day);
		pick_date(p.second_year, p.second_month, p.second_day);
		return p;
	endfunction

	// Offer one word, idling at random beforehand, and record the expected
	// result at the edge where the block takes it.
	task automatic send_pair(input date_pair_t p, input bit known, input span_word_t want);
		span_word_t w;
		while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
			dates.valid <= 1'b0;
			@(posedge clk);
		end
		dates.valid        <= 1'b1;
		dates.first_month  <= p.first_month;
		dates.first_day    <= p.first_day;
		dates.first_year   <= p.first_year;
		dates.second_month <= p.second_month;
		dates.second_day   <= p.second_day;
		dates.second_year  <= p.second_year;
		@(posedge clk);
		while (!dates.ready) begin
			@(posedge clk);
		end
		w = known ? want : predict_span(p);
		pending_spans.push_back(w);
		pairs_sent++;
		if (w.first_valid && w.second_valid) begin
			pairs_valid++;
		end else begin
			pairs_flagged++;
		end
	endtask

	// ---------------------------------------------------------------------
	// Main sequence.
	// ---------------------------------------------------------------------

	initial begin
		dates.valid        <= 1'b0;
		dates.first_month  <= '0;
		dates.first_day    <= '0;
		dates.first_year   <= '0;
		dates.second_month <= '0;
		dates.second_day   <= '0;
		dates.second_year  <= '0;

		// Directed table. Columns: first date, second date, then whether the
		// result is typed in, and if so the span and the two validity flags.
		// Identical dates right after reset, and the smallest positive step.
		add_row(ddays_pkg::MONTH_JAN,  1,     1, ddays_pkg::MONTH_JAN,  1,     1, 1,  0, 1, 1);
		add_row(ddays_pkg::MONTH_JAN,  1,     1, ddays_pkg::MONTH_JAN,  2,     1, 1,  1, 1, 1);
		// Month codes outside the calendar, including all ones in every field.
		add_row(4'd0,                  1,  2000, ddays_pkg::MONTH_JAN,  1,  2000, 1,  0, 0, 1);
		add_row(ddays_pkg::MONTH_JAN,  1,  2000, 4'd13,                 1,  2000, 1,  0, 1, 0);
		add_row(4'd15,                31, 16383, 4'd15,                31, 16383, 1,  0, 0, 0);
		// Day zero, and a day past the end of a 30-day month.
		add_row(ddays_pkg::MONTH_MAR,  0,  2020, ddays_pkg::MONTH_MAR,  1,  2020, 1,  0, 0, 1);
		add_row(ddays_pkg::MONTH_APR, 31,  2021, ddays_pkg::MONTH_MAY,  1,  2021, 1,  0, 0, 1);
		add_row(ddays_pkg::MONTH_NOV, 30,  2021, ddays_pkg::MONTH_NOV, 31,  2021, 1,  0, 1, 0);
		// February 29 in a plain century, a 400th year, and year zero.
		add_row(ddays_pkg::MONTH_FEB, 29,  1900, ddays_pkg::MONTH_MAR,  1,  1900, 1,  0, 0, 1);
		add_row(ddays_pkg::MONTH_FEB, 28,  1900, ddays_pkg::MONTH_MAR,  1,  1900, 1,  1, 1, 1);
		add_row(ddays_pkg::MONTH_FEB, 29,  2000, ddays_pkg::MONTH_MAR,  1,  2000, 1,  1, 1, 1);
		add_row(ddays_pkg::MONTH_FEB, 29,     0, ddays_pkg::MONTH_MAR,  1,     0, 1,  1, 1, 1);
		// Year zero adds no whole years, just like year one.
		add_row(ddays_pkg::MONTH_JAN,  1,     0, ddays_pkg::MONTH_JAN,  1,     1, 1,  0, 1, 1);
		// Years above the top year saturate, also for the February leap test.
		add_row(ddays_pkg::MONTH_JAN,  1, 16383, ddays_pkg::MONTH_JAN,  1,  9999, 1,  0, 1, 1);
		add_row(ddays_pkg::MONTH_FEB, 29, 12000, ddays_pkg::MONTH_JAN,  1,  2000, 1,  0, 0, 1);
		// Across a year end in both directions.
		add_row(ddays_pkg::MONTH_DEC, 31,  2023, ddays_pkg::MONTH_JAN,  1,  2024, 1,  1, 1, 1);
		add_row(ddays_pkg::MONTH_JAN,  1,  2024, ddays_pkg::MONTH_DEC, 31,  2023, 1, -1, 1, 1);
		// The widest spans in both directions, and more pairs, all from the predictor.
		add_row(ddays_pkg::MONTH_JAN,  1,     1, ddays_pkg::MONTH_DEC, 31,  9999, 0,  0, 0, 0);
		add_row(ddays_pkg::MONTH_DEC, 31,  9999, ddays_pkg::MONTH_JAN,  1,     0, 0,  0, 0, 0);
		add_row(ddays_pkg::MONTH_DEC, 31,     0, ddays_pkg::MONTH_DEC, 31,  9999, 0,  0, 0, 0);
		add_row(ddays_pkg::MONTH_FEB, 29,  9996, ddays_pkg::MONTH_JAN,  1,  2001, 0,  0, 0, 0);
		add_row(ddays_pkg::MONTH_JAN,  1,  2001, ddays_pkg::MONTH_JAN,  1,  2000, 0,  0, 0, 0);
		add_row(ddays_pkg::MONTH_MAR,  1,  2100, ddays_pkg::MONTH_FEB, 29,  2400, 0,  0, 0, 0);
		add_row(ddays_pkg::MONTH_SEP, 14,  1752, ddays_pkg::MONTH_JUL,  4,  1776, 0,  0, 0, 0);
		add_row(ddays_pkg::MONTH_JUN, 30,  1969, ddays_pkg::MONTH_AUG, 31,  8191, 0,  0, 0, 0);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (date_table[i]) begin
			send_pair(date_table[i].pair, date_table[i].known, date_table[i].want);
		end

		// Random part; a stretch in the middle runs with both sides always busy.
		for (int i = 0; i < RANDOM_PAIRS; i++) begin
			steady <= (i >= STEADY_FIRST) && (i < STEADY_LAST);
			send_pair(random_pair(), 1'b0, '0);
		end
		steady      <= 1'b0;
		dates.valid <= 1'b0;

		// Let the pipeline drain, then keep waiting so that any stray word it might
		// still put out shows.
		while (pending_spans.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d date pairs: %0d with both dates valid, %0d with a date rejected.",
			pairs_sent, pairs_valid, pairs_flagged);
		$display("Checked %0d result words; %0d mismatches.", spans_checked, fail_count);
		if (fail_count == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

	// The result side stalls at random, except during the steady stretch.
	always @(posedge clk) begin
		result.ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
	end

	// Every accepted result word is compared with the oldest expected word.
	always @(posedge clk) begin : check_results
		span_word_t want;
		if (arst_n && result.valid && result.ready) begin
			if (pending_spans.size() == 0) begin
				$error("unexpected result word: day_difference %0d", result.day_difference);
				fail_count++;
			end else begin
				want = pending_spans.pop_front();
				spans_checked++;
				if (result.day_difference !== want.day_difference) begin
					$error("day_difference: expected %0d, got %0d",
						want.day_difference, result.day_difference);
					fail_count++;
				end
				if (result.first_valid !== want.first_valid) begin
					$error("first_valid: expected %0b, got %0b",
						want.first_valid, result.first_valid);
					fail_count++;
				end
				if (result.second_valid !== want.second_valid) begin
					$error("second_valid: expected %0b, got %0b",
						want.second_valid, result.second_valid);
					fail_count++;
				end
			end
		end
	end

	// Watchdog: a correct run finishes far below this count.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d results outstanding.",
				cycle_count, pending_spans.size());
			$display("tb failed");
			$finish;
		end
	end

endmodule
